FILE: src/asrt_pkg.sv
// shared types, constants and register/rotation codes for the box transform
// no dependencies; imported by every other file of the block
package asrt_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int PROD_WIDTH  = 2 * COORD_WIDTH;
  localparam int CFG_IDX_W   = 3;
  localparam int MODE_W      = 4;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [PROD_WIDTH-1:0]  prod_t;
  typedef coord_t [2:0] corner_t;
  typedef prod_t  [2:0] corner_prod_t;

  typedef struct packed {
    corner_t lo;
    corner_t hi;
  } box_t;

  typedef struct packed {
    corner_prod_t lo;
    corner_prod_t hi;
  } box_prod_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam coord_t SCALE_ONE = coord_t'({{(COORD_WIDTH-1){1'b0}}, 1'b1} << FRAC_BITS);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_MODE = 3'd6;

  // rotation mode codes
  localparam logic [MODE_W-1:0] ROT_NONE = 4'd0;
  localparam logic [MODE_W-1:0] ROT_X90  = 4'd1;
  localparam logic [MODE_W-1:0] ROT_X180 = 4'd2;
  localparam logic [MODE_W-1:0] ROT_X270 = 4'd3;
  localparam logic [MODE_W-1:0] ROT_Y90  = 4'd4;
  localparam logic [MODE_W-1:0] ROT_Y180 = 4'd5;
  localparam logic [MODE_W-1:0] ROT_Y270 = 4'd6;
  localparam logic [MODE_W-1:0] ROT_Z90  = 4'd7;
  localparam logic [MODE_W-1:0] ROT_Z180 = 4'd8;
  localparam logic [MODE_W-1:0] ROT_Z270 = 4'd9;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic [1:0] QTR_90  = 2'd1;
  localparam logic [1:0] QTR_180 = 2'd2;
  localparam logic [1:0] QTR_270 = 2'd3;

  typedef struct packed {
    logic       en;
    logic [1:0] axis;
    logic [1:0] quarter;
  } rot_ctrl_t;

endpackage

FILE: src/asrt_if.sv
// valid/ready channel interfaces for input boxes and result boxes
// depends on asrt_pkg
interface asrt_in_if;
  import asrt_pkg::*;
  logic   valid;
  logic   ready;
  coord_t in_min_x;
  coord_t in_min_y;
  coord_t in_min_z;
  coord_t in_max_x;
  coord_t in_max_y;
  coord_t in_max_z;
  modport source (output valid, in_min_x, in_min_y, in_min_z,
                  in_max_x, in_max_y, in_max_z, input ready);
  modport sink   (input valid, in_min_x, in_min_y, in_min_z,
                  in_max_x, in_max_y, in_max_z, output ready);
endinterface

interface asrt_out_if;
  import asrt_pkg::*;
  logic   valid;
  logic   ready;
  coord_t out_min_x;
  coord_t out_min_y;
  coord_t out_min_z;
  coord_t out_max_x;
  coord_t out_max_y;
  coord_t out_max_z;
  modport source (output valid, out_min_x, out_min_y, out_min_z,
                  out_max_x, out_max_y, out_max_z, input ready);
  modport sink   (input valid, out_min_x, out_min_y, out_min_z,
                  out_max_x, out_max_y, out_max_z, output ready);
endinterface

FILE: src/asrt_mul.sv
// scale stages: six parallel signed products, then floor shift and saturation
// depends on asrt_pkg
module asrt_mul (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  asrt_pkg::box_t   in_box,
  input  asrt_pkg::corner_t scale,
  output logic             out_valid,
  input  logic             out_ready,
  output asrt_pkg::box_t   out_box
);
  import asrt_pkg::*;

  // arithmetic shift floors; then clamp to the coordinate range
  function automatic coord_t shift_sat(prod_t p);
    prod_t                   sh;
    logic [COORD_WIDTH:0]    top;
    sh  = p >>> FRAC_BITS;
    top = sh[PROD_WIDTH-1:COORD_WIDTH-1];
    if ((&top) || !(|top)) begin
      return sh[COORD_WIDTH-1:0];
    end else if (sh[PROD_WIDTH-1]) begin
      return COORD_MIN;
    end else begin
      return COORD_MAX;
    end
  endfunction

  logic      prod_valid;
  logic      prod_ready;
  box_prod_t prod;

  assign in_ready   = !prod_valid || prod_ready;
  assign prod_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (in_ready) begin
      prod_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      for (int k = 0; k < 3; k++) begin
        prod.lo[k] <= prod_t'($signed(in_box.lo[k])) * prod_t'($signed(scale[k]));
        prod.hi[k] <= prod_t'($signed(in_box.hi[k])) * prod_t'($signed(scale[k]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (prod_ready) begin
      out_valid <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_ready && prod_valid) begin
      for (int k = 0; k < 3; k++) begin
        out_box.lo[k] <= shift_sat(prod.lo[k]);
        out_box.hi[k] <= shift_sat(prod.hi[k]);
      end
    end
  end

endmodule

FILE: src/asrt_rotate.sv
// rotate stage: when a turn is enabled, quarter turn of both corners, then per-axis min/max ordering
// depends on asrt_pkg
module asrt_rotate (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  asrt_pkg::box_t      in_box,
  input  asrt_pkg::rot_ctrl_t ctrl,
  output logic                out_valid,
  input  logic                out_ready,
  output asrt_pkg::box_t      out_box
);
  import asrt_pkg::*;

  function automatic coord_t neg_sat(coord_t a);
    if (a == COORD_MIN) begin
      return COORD_MAX;
    end
    return -a;
  endfunction

  function automatic corner_t turn(corner_t p, rot_ctrl_t r);
    corner_t    q;
    logic [1:0] b;
    logic [1:0] c;
    coord_t     u;
    coord_t     v;
    q = p;
    case (r.axis)
      AXIS_X:  begin b = 2'd1; c = 2'd2; end
      AXIS_Y:  begin b = 2'd2; c = 2'd0; end
      default: begin b = 2'd0; c = 2'd1; end
    endcase
    u = p[b];
    v = p[c];
    case (r.quarter)
      QTR_90: begin
        q[b] = neg_sat(v);
        q[c] = u;
      end
      QTR_180: begin
        q[b] = neg_sat(u);
        q[c] = neg_sat(v);
      end
      default: begin
        q[b] = v;
        q[c] = neg_sat(u);
      end
    endcase
    return q;
  endfunction

  corner_t lo_turn;
  corner_t hi_turn;
  box_t    box_next;

  always_comb begin
    lo_turn  = turn(in_box.lo, ctrl);
    hi_turn  = turn(in_box.hi, ctrl);
    box_next = in_box;
    if (ctrl.en) begin
      for (int k = 0; k < 3; k++) begin
        if ($signed(lo_turn[k]) >= $signed(hi_turn[k])) begin
          box_next.lo[k] = hi_turn[k];
          box_next.hi[k] = lo_turn[k];
        end else begin
          box_next.lo[k] = lo_turn[k];
          box_next.hi[k] = hi_turn[k];
        end
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_box <= box_next;
    end
  end

endmodule

FILE: src/asrt_offset.sv
// translate stage: saturating add of per-axis offsets into the output register
// depends on asrt_pkg
module asrt_offset (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  asrt_pkg::box_t    in_box,
  input  asrt_pkg::corner_t offset,
  output logic              out_valid,
  input  logic              out_ready,
  output asrt_pkg::box_t    out_box
);
  import asrt_pkg::*;

  function automatic coord_t add_sat(coord_t a, coord_t b);
    logic signed [COORD_WIDTH:0] s;
    s = {a[COORD_WIDTH-1], a} + {b[COORD_WIDTH-1], b};
    if (s[COORD_WIDTH] != s[COORD_WIDTH-1]) begin
      return s[COORD_WIDTH] ? COORD_MIN : COORD_MAX;
    end
    return s[COORD_WIDTH-1:0];
  endfunction

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      for (int k = 0; k < 3; k++) begin
        out_box.lo[k] <= add_sat(in_box.lo[k], offset[k]);
        out_box.hi[k] <= add_sat(in_box.hi[k], offset[k]);
      end
    end
  end

endmodule

FILE: src/aabb_scale_rotate_translate.sv
// top level of the axis-aligned box scale / rotate / translate pipeline
// depends on asrt_pkg, asrt_if, asrt_mul, asrt_rotate, asrt_offset
//
// Each word on in_box is one box (min and max corner, signed Q16.16). The
// block scales every coordinate by its axis scale (floor of the product,
// saturated), applies the selected quarter-turn about X, Y or Z, reorders
// min and max per axis after a turn, and adds the per-axis offsets with
// saturation. A box passes four register stages: product, shift/saturate,
// rotate/order, offset add; its result word is valid on out_box from the
// offset add register. A new box can be accepted every cycle; each stage
// holds its word when the next one is full, so throughput is one box per
// cycle as long as out_box takes words.
// Configuration writes take effect at once and should be made only with
// the pipeline empty.
module aabb_scale_rotate_translate (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [asrt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [asrt_pkg::COORD_WIDTH-1:0]   cfg_data,
  asrt_in_if.sink                            in_box,
  asrt_out_if.source                         out_box
);
  import asrt_pkg::*;

  // configuration registers
  coord_t            scale_x;
  coord_t            scale_y;
  coord_t            scale_z;
  coord_t            offset_x;
  coord_t            offset_y;
  coord_t            offset_z;
  logic [MODE_W-1:0] rotation_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_x       <= SCALE_ONE;
      scale_y       <= SCALE_ONE;
      scale_z       <= SCALE_ONE;
      offset_x      <= '0;
      offset_y      <= '0;
      offset_z      <= '0;
      rotation_mode <= ROT_NONE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCALE_X:  scale_x       <= cfg_data;
        REG_SCALE_Y:  scale_y       <= cfg_data;
        REG_SCALE_Z:  scale_z       <= cfg_data;
        REG_OFFSET_X: offset_x      <= cfg_data;
        REG_OFFSET_Y: offset_y      <= cfg_data;
        REG_OFFSET_Z: offset_z      <= cfg_data;
        REG_ROT_MODE: rotation_mode <= cfg_data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // rotation decode; unused codes behave as no rotation
  rot_ctrl_t rot_ctrl;

  always_comb begin
    rot_ctrl = '{en: 1'b0, axis: AXIS_X, quarter: QTR_90};
    case (rotation_mode)
      ROT_X90:  rot_ctrl = '{en: 1'b1, axis: AXIS_X, quarter: QTR_90};
      ROT_X180: rot_ctrl = '{en: 1'b1, axis: AXIS_X, quarter: QTR_180};
      ROT_X270: rot_ctrl = '{en: 1'b1, axis: AXIS_X, quarter: QTR_270};
      ROT_Y90:  rot_ctrl = '{en: 1'b1, axis: AXIS_Y, quarter: QTR_90};
      ROT_Y180: rot_ctrl = '{en: 1'b1, axis: AXIS_Y, quarter: QTR_180};
      ROT_Y270: rot_ctrl = '{en: 1'b1, axis: AXIS_Y, quarter: QTR_270};
      ROT_Z90:  rot_ctrl = '{en: 1'b1, axis: AXIS_Z, quarter: QTR_90};
      ROT_Z180: rot_ctrl = '{en: 1'b1, axis: AXIS_Z, quarter: QTR_180};
      ROT_Z270: rot_ctrl = '{en: 1'b1, axis: AXIS_Z, quarter: QTR_270};
      default:  rot_ctrl = '{en: 1'b0, axis: AXIS_X, quarter: QTR_90};
    endcase
  end

  // per-axis views of the registers, index 0 is x
  corner_t scale_v;
  corner_t offset_v;

  assign scale_v[0]  = scale_x;
  assign scale_v[1]  = scale_y;
  assign scale_v[2]  = scale_z;
  assign offset_v[0] = offset_x;
  assign offset_v[1] = offset_y;
  assign offset_v[2] = offset_z;

  // input word to box
  box_t in_word;

  assign in_word.lo[0] = in_box.in_min_x;
  assign in_word.lo[1] = in_box.in_min_y;
  assign in_word.lo[2] = in_box.in_min_z;
  assign in_word.hi[0] = in_box.in_max_x;
  assign in_word.hi[1] = in_box.in_max_y;
  assign in_word.hi[2] = in_box.in_max_z;

  // scale: two stages
  logic mul_valid;
  logic mul_ready;
  box_t mul_box;

  asrt_mul u_mul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_box.valid),
    .in_ready  (in_box.ready),
    .in_box    (in_word),
    .scale     (scale_v),
    .out_valid (mul_valid),
    .out_ready (mul_ready),
    .out_box   (mul_box)
  );

  // rotate and order: one stage
  logic rot_valid;
  logic rot_ready;
  box_t rot_box;

  asrt_rotate u_rotate (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mul_valid),
    .in_ready  (mul_ready),
    .in_box    (mul_box),
    .ctrl      (rot_ctrl),
    .out_valid (rot_valid),
    .out_ready (rot_ready),
    .out_box   (rot_box)
  );

  // translate: output register
  box_t res_box;

  asrt_offset u_offset (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rot_valid),
    .in_ready  (rot_ready),
    .in_box    (rot_box),
    .offset    (offset_v),
    .out_valid (out_box.valid),
    .out_ready (out_box.ready),
    .out_box   (res_box)
  );

  assign out_box.out_min_x = res_box.lo[0];
  assign out_box.out_min_y = res_box.lo[1];
  assign out_box.out_min_z = res_box.lo[2];
  assign out_box.out_max_x = res_box.hi[0];
  assign out_box.out_max_y = res_box.hi[1];
  assign out_box.out_max_z = res_box.hi[2];

endmodule

FILE: verif/aabb_scale_rotate_translate_tb.sv
// self-checking testbench for the box scale / quarter-turn / offset pipeline
// depends on asrt_pkg, asrt_if and the aabb_scale_rotate_translate top level
// directed corner cases, then randomized settings and boxes with random idling
module aabb_scale_rotate_translate_tb;
  import asrt_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 2;
  // four pipeline stages, with margin
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 300;
  localparam int RAND_PHASES   = 20;
  localparam int CALM_PHASES   = 4;
  localparam int DRAIN_LIMIT   = 200000;
  localparam int RUN_LIMIT     = 6000000;

  // index past the last register, writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  // rotation codes with no meaning, behave like no rotation
  localparam logic [MODE_W-1:0] ROT_SPARE_LO = 4'd10;
  localparam logic [MODE_W-1:0] ROT_SPARE_HI = 4'd15;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [COORD_WIDTH-1:0] cfg_data  = '0;

  // source / sink side registers, wired onto the channels below
  logic src_valid  = 1'b0;
  box_t src_box    = '0;
  logic sink_ready = 1'b0;

  asrt_in_if  in_box_if ();
  asrt_out_if out_box_if ();

  assign in_box_if.valid    = src_valid;
  assign in_box_if.in_min_x = src_box.lo[0];
  assign in_box_if.in_min_y = src_box.lo[1];
  assign in_box_if.in_min_z = src_box.lo[2];
  assign in_box_if.in_max_x = src_box.hi[0];
  assign in_box_if.in_max_y = src_box.hi[1];
  assign in_box_if.in_max_z = src_box.hi[2];
  assign out_box_if.ready   = sink_ready;

  aabb_scale_rotate_translate u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_box   (in_box_if),
    .out_box  (out_box_if)
  );

  always #(CLK_HALF) clk = ~clk;

  // shadow copy of the register file, only changed while the pipe is empty
  coord_t           axis_scale  [3];
  coord_t           axis_offset [3];
  logic [MODE_W-1:0] turn_mode;

  box_t box_in_q  [$];   // boxes waiting to be offered
  box_t box_exp_q [$];   // transformed boxes still owed by the block

  int    fails         = 0;
  int    boxes_checked = 0;
  int    configs       = 0;
  int    burst_pct     = 0;   // chance of an idle burst per free cycle, both sides
  int    hold_req      = 0;   // bumped to ask the sink for one long hold-off
  string axis_tag [3]  = '{"x", "y", "z"};

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic coord_t sat_coord(longint v);
    if (v > longint'(COORD_MAX)) return COORD_MAX;
    if (v < longint'(COORD_MIN)) return COORD_MIN;
    return coord_t'(v);
  endfunction

  // full product, floor shift by the fraction bits, then clamp
  function automatic coord_t scaled(coord_t a, coord_t s);
    longint prod;
    prod = longint'(a) * longint'(s);
    return sat_coord(prod >>> FRAC_BITS);
  endfunction

  // the most negative value has no positive twin and clamps to the top
  function automatic coord_t neg_sat(coord_t a);
    if (a == COORD_MIN) return COORD_MAX;
    return -a;
  endfunction

  function automatic coord_t add_sat(coord_t a, coord_t b);
    return sat_coord(longint'(a) + longint'(b));
  endfunction

  function automatic box_t predict_box(box_t b);
    coord_t     c [2][3];
    coord_t     u;
    coord_t     v;
    logic [1:0] ax;
    logic [1:0] q;
    int         bi;
    int         ci;
    bit         turned;
    box_t       r;
    turned = 1'b1;
    ax     = AXIS_X;
    q      = QTR_90;
    for (int k = 0; k < 3; k++) begin
      c[0][k] = scaled(b.lo[k], axis_scale[k]);
      c[1][k] = scaled(b.hi[k], axis_scale[k]);
    end
    case (turn_mode)
      ROT_X90:  begin ax = AXIS_X; q = QTR_90;  end
      ROT_X180: begin ax = AXIS_X; q = QTR_180; end
      ROT_X270: begin ax = AXIS_X; q = QTR_270; end
      ROT_Y90:  begin ax = AXIS_Y; q = QTR_90;  end
      ROT_Y180: begin ax = AXIS_Y; q = QTR_180; end
      ROT_Y270: begin ax = AXIS_Y; q = QTR_270; end
      ROT_Z90:  begin ax = AXIS_Z; q = QTR_90;  end
      ROT_Z180: begin ax = AXIS_Z; q = QTR_180; end
      ROT_Z270: begin ax = AXIS_Z; q = QTR_270; end
      default:  turned = 1'b0;   // none, and the spare codes
    endcase
    // the two axes that move: about X it is (y,z), about Y (z,x), about Z (x,y)
    case (ax)
      AXIS_X:  begin bi = 1; ci = 2; end
      AXIS_Y:  begin bi = 2; ci = 0; end
      default: begin bi = 0; ci = 1; end
    endcase
    if (turned) begin
      for (int s = 0; s < 2; s++) begin
        u = c[s][bi];
        v = c[s][ci];
        case (q)
          QTR_90:  begin c[s][bi] = neg_sat(v); c[s][ci] = u;          end
          QTR_180: begin c[s][bi] = neg_sat(u); c[s][ci] = neg_sat(v); end
          default: begin c[s][bi] = v;          c[s][ci] = neg_sat(u); end
        endcase
      end
      // reorder only after a turn; an unturned box keeps min > max as given
      for (int k = 0; k < 3; k++) begin
        if (c[0][k] >= c[1][k]) begin
          u       = c[0][k];
          c[0][k] = c[1][k];
          c[1][k] = u;
        end
      end
    end
    for (int k = 0; k < 3; k++) begin
      r.lo[k] = add_sat(c[0][k], axis_offset[k]);
      r.hi[k] = add_sat(c[1][k], axis_offset[k]);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic box_t make_box(coord_t lx, coord_t ly, coord_t lz,
                                    coord_t hx, coord_t hy, coord_t hz);
    box_t b;
    b.lo[0] = lx; b.lo[1] = ly; b.lo[2] = lz;
    b.hi[0] = hx; b.hi[1] = hy; b.hi[2] = hz;
    return b;
  endfunction

  // mix of rails, zero, small values around the origin and raw 32-bit noise
  function automatic coord_t rand_coord();
    int t;
    case ($urandom_range(0, 9))
      0:       return COORD_MIN;
      1:       return COORD_MAX;
      2:       return '0;
      3, 4, 5: begin
        t = $urandom_range(0, 2097151);
        return coord_t'(t - 1048576);
      end
      default: return coord_t'($urandom());
    endcase
  endfunction

  // mostly within +-4.0 so results stay off the rails, sometimes extremes
  function automatic coord_t rand_scale();
    int t;
    case ($urandom_range(0, 9))
      0:       return COORD_MIN;
      1:       return COORD_MAX;
      2:       return '0;
      3:       return SCALE_ONE;
      4, 5:    return coord_t'($urandom());
      default: begin
        t = $urandom_range(0, 8 * 65536);
        return coord_t'(t - 4 * 65536);
      end
    endcase
  endfunction

  function automatic coord_t rand_offset();
    int t;
    case ($urandom_range(0, 7))
      0:       return COORD_MIN;
      1:       return COORD_MAX;
      2:       return coord_t'($urandom());
      3:       return '0;
      default: begin
        t = $urandom_range(0, 128 * 65536);
        return coord_t'(t - 64 * 65536);
      end
    endcase
  endfunction

  // call right after a rising edge; leaves cfg_we high, caller lowers it
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input coord_t data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_SCALE_X:  axis_scale[0]  = data;
      REG_SCALE_Y:  axis_scale[1]  = data;
      REG_SCALE_Z:  axis_scale[2]  = data;
      REG_OFFSET_X: axis_offset[0] = data;
      REG_OFFSET_Y: axis_offset[1] = data;
      REG_OFFSET_Z: axis_offset[2] = data;
      REG_ROT_MODE: turn_mode      = data[MODE_W-1:0];
      default:      ;
    endcase
  endtask

  // waits until every queued box is sent and every owed box is back, then lets the pipe settle
  task automatic wait_drained();
    int spent;
    spent = 0;
    while ((box_in_q.size() != 0 || src_valid || box_exp_q.size() != 0)
           && spent < DRAIN_LIMIT) begin
      @(posedge clk);
      spent++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // driver: offers queued boxes, holds a word until it is taken
  // ---------------------------------------------------------------------------

  int   gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      src_valid <= 1'b0;
    end else begin
      // expectation is formed at the accepting edge with the current settings
      if (src_valid && in_box_if.ready) begin
        box_exp_q.push_back(predict_box(src_box));
      end
      if (!src_valid || in_box_if.ready) begin
        if (gap_left == 0 && burst_pct != 0 && $urandom_range(0, 99) < burst_pct) begin
          gap_left = $urandom_range(1, 5);
        end
        if (gap_left > 0) begin
          gap_left--;
          src_valid <= 1'b0;
        end else if (box_in_q.size() != 0) begin
          src_box   <= box_in_q.pop_front();
          src_valid <= 1'b1;
        end else begin
          src_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each result word against the oldest owed box
  // ---------------------------------------------------------------------------

  int   stall_left = 0;
  int   hold_seen  = 0;
  box_t mon_got;
  box_t mon_want;

  always @(posedge clk) begin
    if (rst) begin
      sink_ready <= 1'b0;
    end else begin
      if (out_box_if.valid && sink_ready) begin
        mon_got = make_box(out_box_if.out_min_x, out_box_if.out_min_y,
                           out_box_if.out_min_z, out_box_if.out_max_x,
                           out_box_if.out_max_y, out_box_if.out_max_z);
        if (box_exp_q.size() == 0) begin
          $error("result word with no box owed");
          fails++;
        end else begin
          mon_want = box_exp_q.pop_front();
          boxes_checked++;
          for (int k = 0; k < 3; k++) begin
            if (mon_got.lo[k] !== mon_want.lo[k]) begin
              $error("out_min_%s expected %0d got %0d", axis_tag[k],
                     mon_want.lo[k], mon_got.lo[k]);
              fails++;
            end
            if (mon_got.hi[k] !== mon_want.hi[k]) begin
              $error("out_max_%s expected %0d got %0d", axis_tag[k],
                     mon_want.hi[k], mon_got.hi[k]);
              fails++;
            end
          end
        end
      end
      // a long hold-off on request, otherwise short random bursts
      if (hold_req != hold_seen) begin
        hold_seen  = hold_req;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && burst_pct != 0 &&
                   $urandom_range(0, 99) < burst_pct) begin
        stall_left = $urandom_range(1, 5);
      end
      if (stall_left > 0) begin
        stall_left--;
        sink_ready <= 1'b0;
      end else begin
        sink_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequence of phases
  // ---------------------------------------------------------------------------

  logic [MODE_W-1:0] turn_list [11] = '{ROT_X90, ROT_X180, ROT_X270, ROT_Y90, ROT_Y180,
                                        ROT_Y270, ROT_Z90, ROT_Z180, ROT_Z270,
                                        ROT_SPARE_LO, ROT_SPARE_HI};

  initial begin : stimulus
    int                n_items;
    int                m;
    logic [MODE_W-1:0] mode;
    box_t              rail_box;
    box_t              flat_box;

    for (int k = 0; k < 3; k++) begin
      axis_scale[k]  = SCALE_ONE;
      axis_offset[k] = '0;
    end
    turn_mode = ROT_NONE;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    burst_pct = 20;
    configs   = 1;

    // reset settings: identity, rails, and an inverted box left as it is
    box_in_q.push_back(make_box('0, '0, '0, '0, '0, '0));
    box_in_q.push_back(make_box(COORD_MIN, COORD_MIN, COORD_MIN,
                                COORD_MAX, COORD_MAX, COORD_MAX));
    box_in_q.push_back(make_box(COORD_MAX, COORD_MAX, COORD_MAX,
                                COORD_MIN, COORD_MIN, COORD_MIN));
    wait_drained();

    // half scales on x and y show floor rounding of negatives, offsets at the rails on x and y
    write_reg(REG_SCALE_X, coord_t'(32'sh0000_8000));
    write_reg(REG_SCALE_Y, coord_t'(-32'sh0000_8000));
    write_reg(REG_SCALE_Z, coord_t'(32'sh0003_0001));
    write_reg(REG_OFFSET_X, COORD_MAX);
    write_reg(REG_OFFSET_Y, COORD_MIN);
    write_reg(REG_OFFSET_Z, coord_t'(1));
    write_reg(REG_ROT_MODE, coord_t'(ROT_NONE));
    cfg_we <= 1'b0;
    configs++;
    box_in_q.push_back(make_box(-1, 1, -3, 1, -1, 3));
    box_in_q.push_back(make_box(COORD_MAX, COORD_MAX, COORD_MIN,
                                COORD_MIN, COORD_MIN, COORD_MAX));
    wait_drained();

    // most negative scale saturates products, then every turn negates a rail
    write_reg(REG_UNUSED, coord_t'(32'h0000_0005));
    write_reg(REG_SCALE_X, COORD_MIN);
    write_reg(REG_SCALE_Y, COORD_MIN);
    write_reg(REG_SCALE_Z, COORD_MIN);
    write_reg(REG_OFFSET_X, '0);
    write_reg(REG_OFFSET_Y, '0);
    write_reg(REG_OFFSET_Z, '0);
    cfg_we <= 1'b0;
    rail_box = make_box(COORD_MIN, 1, 32'sh0001_0000, COORD_MAX, -32'sh0001_0000, '0);
    // equal min and max so the reorder has nothing to do
    flat_box = make_box(32'sh0001_2345, -7, COORD_MIN, 32'sh0001_2345, -7, COORD_MIN);
    for (int i = 0; i < 11; i++) begin
      wait_drained();
      write_reg(REG_ROT_MODE, coord_t'(turn_list[i]));
      cfg_we <= 1'b0;
      configs++;
      box_in_q.push_back((i % 4 == 3) ? flat_box : rail_box);
    end

    // random settings, random boxes
    for (int p = 0; p < RAND_PHASES; p++) begin
      wait_drained();
      if (p >= RAND_PHASES - CALM_PHASES) begin
        burst_pct = 0;
      end else begin
        case ($urandom_range(0, 3))
          0:       burst_pct = 0;
          1:       burst_pct = 10;
          2:       burst_pct = 25;
          default: burst_pct = 40;
        endcase
      end
      m = $urandom_range(0, 19);
      if (m > 15) m = $urandom_range(1, 9);
      mode = m[MODE_W-1:0];
      write_reg(REG_SCALE_X, rand_scale());
      write_reg(REG_SCALE_Y, rand_scale());
      write_reg(REG_SCALE_Z, rand_scale());
      write_reg(REG_OFFSET_X, rand_offset());
      write_reg(REG_OFFSET_Y, rand_offset());
      write_reg(REG_OFFSET_Z, rand_offset());
      // upper data bits of the mode write are noise and must not matter
      write_reg(REG_ROT_MODE, coord_t'({$urandom_range(0, 32'h0FFF_FFFF), mode}));
      if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, coord_t'($urandom()));
      cfg_we <= 1'b0;
      configs++;
      n_items = $urandom_range(70, 130);
      for (int i = 0; i < n_items; i++) begin
        box_in_q.push_back(make_box(rand_coord(), rand_coord(), rand_coord(),
                                    rand_coord(), rand_coord(), rand_coord()));
      end
      // sink sits still while the source keeps offering, pipe fills and backs up
      if (p == 3) hold_req++;
    end

    wait_drained();
    if (box_exp_q.size() != 0) begin
      $error("%0d boxes never came back", box_exp_q.size());
      fails++;
    end
    $display("checked %0d boxes over %0d register settings", boxes_checked, configs);
    $display("covered all nine turns, spare modes, rails, floor rounding, long sink stall");
    if (fails == 0) begin
      $display("PASS aabb_scale_rotate_translate");
    end else begin
      $display("FAIL aabb_scale_rotate_translate");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #(RUN_LIMIT);
    $display("FAIL aabb_scale_rotate_translate");
    $finish;
  end

endmodule

FILE: sim.f
src/asrt_pkg.sv
src/asrt_if.sv
src/asrt_mul.sv
src/asrt_rotate.sv
src/asrt_offset.sv
src/aabb_scale_rotate_translate.sv
verif/aabb_scale_rotate_translate_tb.sv
